>>> hdl/blw_pkg.sv
// Shared types and constants for the Bresenham line pixel writer.
// Used by the channel interfaces and by every module of the block.
package blw_pkg;

    localparam int COORD_BITS = 10;
    localparam int ROW_BITS   = 9;
    localparam int ADDR_BITS  = 18;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int LEVEL_BITS = 2;
    localparam int SHIFT_BITS = 3;

    localparam logic [ROW_BITS-1:0] ROW_BYTES_RESET = ROW_BITS'(74);

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_cmd                  command;
        t_coord                start_x;
        t_coord                start_y;
        t_coord                end_x;
        t_coord                end_y;
        logic [LEVEL_BITS-1:0] gray_level;
    } t_in;

    typedef struct packed {
        logic                  write_valid;
        t_coord                pixel_x;
        t_coord                pixel_y;
        logic [LEVEL_BITS-1:0] pixel_value;
        logic                  last_pixel;
    } t_pix;

    typedef struct packed {
        logic                  write_valid;
        t_coord                pixel_x;
        t_coord                pixel_y;
        logic [ADDR_BITS-1:0]  byte_address;
        logic [SHIFT_BITS-1:0] bit_shift;
        logic [LEVEL_BITS-1:0] pixel_value;
        logic                  last_pixel;
    } t_res;

endpackage

>>> hdl/blw_in_if.sv
// Command channel of the line pixel writer: valid, ready and one command beat.
// Depends on blw_pkg.
interface blw_in_if
    import blw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    t_cmd                  command;
    t_coord                start_x;
    t_coord                start_y;
    t_coord                end_x;
    t_coord                end_y;
    logic [LEVEL_BITS-1:0] gray_level;

    modport source (output valid, command, start_x, start_y, end_x, end_y, gray_level,
                    input ready);
    modport sink   (input valid, command, start_x, start_y, end_x, end_y, gray_level,
                    output ready);
endinterface

>>> hdl/blw_out_if.sv
// Pixel write channel of the line pixel writer: valid, ready and one result beat.
// Depends on blw_pkg.
interface blw_out_if
    import blw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  write_valid;
    t_coord                pixel_x;
    t_coord                pixel_y;
    logic [ADDR_BITS-1:0]  byte_address;
    logic [SHIFT_BITS-1:0] bit_shift;
    logic [LEVEL_BITS-1:0] pixel_value;
    logic                  last_pixel;

    modport source (output valid, write_valid, pixel_x, pixel_y, byte_address, bit_shift,
                    pixel_value, last_pixel, input ready);
    modport sink   (input valid, write_valid, pixel_x, pixel_y, byte_address, bit_shift,
                    pixel_value, last_pixel, output ready);
endinterface

>>> hdl/blw_cfg_if.sv
// Configuration write channel: valid, ready and the row width in bytes.
// Depends on blw_pkg.
interface blw_cfg_if
    import blw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ROW_BITS-1:0] row_bytes;

    modport source (output valid, row_bytes, input ready);
    modport sink   (input valid, row_bytes, output ready);
endinterface

>>> hdl/blw_line_core.sv
// Line state registers and the per-beat Bresenham step: set up on load, one pixel on advance.
// Depends on blw_pkg.
module blw_line_core
    import blw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_item,
    output t_pix o_pix
);

    logic                  r_active;
    logic                  r_steep;
    t_coord                r_major_pos;
    t_coord                r_major_end;
    t_coord                r_minor_pos;
    logic [ERR_BITS-1:0]   r_err;
    t_coord                r_major_delta;
    t_coord                r_minor_delta;
    logic                  r_step_down;
    logic [LEVEL_BITS-1:0] r_level;

    t_coord dx, dy, ma, mb, na, nb;
    logic   steep, swap;
    t_coord ld_major_pos, ld_major_end, ld_minor_pos, ld_minor_end;
    t_coord ld_major_delta, ld_minor_delta;

    logic                is_last;
    logic [ERR_BITS-1:0] err_sub;
    logic [ERR_BITS-1:0] n_err;
    t_coord              n_minor_pos;

    always_comb begin
        dx = (i_item.start_x > i_item.end_x) ? i_item.start_x - i_item.end_x
                                             : i_item.end_x - i_item.start_x;
        dy = (i_item.start_y > i_item.end_y) ? i_item.start_y - i_item.end_y
                                             : i_item.end_y - i_item.start_y;
        steep = dy > dx;
        ma = steep ? i_item.start_y : i_item.start_x;
        mb = steep ? i_item.end_y   : i_item.end_x;
        na = steep ? i_item.start_x : i_item.start_y;
        nb = steep ? i_item.end_x   : i_item.end_y;
        swap = ma > mb;
        ld_major_pos   = swap ? mb : ma;
        ld_major_end   = swap ? ma : mb;
        ld_minor_pos   = swap ? nb : na;
        ld_minor_end   = swap ? na : nb;
        ld_major_delta = steep ? dy : dx;
        ld_minor_delta = steep ? dx : dy;
    end

    always_comb begin
        is_last = r_major_pos == r_major_end;
        err_sub = r_err - {2'b00, r_minor_delta};
        n_err   = err_sub;
        n_minor_pos = r_minor_pos;
        if (err_sub[ERR_BITS-1]) begin
            n_err       = err_sub + {2'b00, r_major_delta};
            n_minor_pos = r_step_down ? r_minor_pos - COORD_BITS'(1)
                                      : r_minor_pos + COORD_BITS'(1);
        end
    end

    always_comb begin
        o_pix = '0;
        if (i_item.command == CMD_ADVANCE && r_active) begin
            o_pix.write_valid = 1'b1;
            o_pix.pixel_x     = r_steep ? r_minor_pos : r_major_pos;
            o_pix.pixel_y     = r_steep ? r_major_pos : r_minor_pos;
            o_pix.pixel_value = r_level;
            o_pix.last_pixel  = is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_accept) begin
            if (i_item.command == CMD_LOAD) begin
                r_active <= 1'b1;
            end else if (r_active && is_last) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (i_item.command == CMD_LOAD) begin
                r_steep       <= steep;
                r_major_pos   <= ld_major_pos;
                r_major_end   <= ld_major_end;
                r_minor_pos   <= ld_minor_pos;
                r_major_delta <= ld_major_delta;
                r_minor_delta <= ld_minor_delta;
                r_err         <= {3'b000, ld_major_delta[COORD_BITS-1:1]};
                r_step_down   <= !(ld_minor_pos < ld_minor_end);
                r_level       <= i_item.gray_level;
            end else if (r_active) begin
                r_err       <= n_err;
                r_minor_pos <= n_minor_pos;
                if (!is_last) begin
                    r_major_pos <= r_major_pos + COORD_BITS'(1);
                end
            end
        end
    end

endmodule

>>> hdl/blw_addr_gen.sv
// Framebuffer byte address and bit shift of one pixel write, two bits per pixel.
// Depends on blw_pkg.
module blw_addr_gen
    import blw_pkg::*;
(
    input  t_pix                i_pix,
    input  logic [ROW_BITS-1:0] i_row_bytes,
    output t_res                o_res
);

    logic [COORD_BITS+ROW_BITS-1:0] row_offset;
    logic [COORD_BITS+ROW_BITS-1:0] addr_sum;

    always_comb begin
        row_offset = (COORD_BITS+ROW_BITS)'(i_pix.pixel_y)
                   * (COORD_BITS+ROW_BITS)'(i_row_bytes);
        addr_sum   = row_offset + (COORD_BITS+ROW_BITS)'(i_pix.pixel_x[COORD_BITS-1:2]);
        o_res = '0;
        if (i_pix.write_valid) begin
            o_res.write_valid  = 1'b1;
            o_res.pixel_x      = i_pix.pixel_x;
            o_res.pixel_y      = i_pix.pixel_y;
            o_res.byte_address = addr_sum[ADDR_BITS-1:0];
            o_res.bit_shift    = {~i_pix.pixel_x[1:0], 1'b0};
            o_res.pixel_value  = i_pix.pixel_value;
            o_res.last_pixel   = i_pix.last_pixel;
        end
    end

endmodule

>>> hdl/bresenham_line_pixel_writer_top.sv
// Top level of the Bresenham line pixel writer: handshake, row width register, result register.
// Depends on blw_pkg, the three channel interfaces, blw_line_core and blw_addr_gen.
//
// Every command beat produces exactly one result beat, in the cycle after it is accepted; a new
// command is accepted in every cycle in which the result register is empty or being drained,
// so the unstalled rate is one beat per clock. Loads and advances while idle return a result
// with write_valid low and all fields zero. The row width register takes a write in any cycle.
module bresenham_line_pixel_writer_top
    import blw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    blw_in_if.sink    i_cmd,
    blw_cfg_if.sink   i_cfg,
    blw_out_if.source o_pix
);

    logic                r_out_valid;
    t_res                r_res;
    logic [ROW_BITS-1:0] r_row_bytes;

    logic in_accept;
    t_in  in_item;
    t_pix pix;
    t_res n_res;

    assign i_cmd.ready = !r_out_valid || o_pix.ready;
    assign in_accept   = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        in_item.command    = i_cmd.command;
        in_item.start_x    = i_cmd.start_x;
        in_item.start_y    = i_cmd.start_y;
        in_item.end_x      = i_cmd.end_x;
        in_item.end_y      = i_cmd.end_y;
        in_item.gray_level = i_cmd.gray_level;
    end

    blw_line_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (in_item),
        .o_pix    (pix)
    );

    blw_addr_gen u_addr (
        .i_pix       (pix),
        .i_row_bytes (r_row_bytes),
        .o_res       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= ROW_BYTES_RESET;
        end else if (i_cfg.valid) begin
            r_row_bytes <= i_cfg.row_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.write_valid  = r_res.write_valid;
    assign o_pix.pixel_x      = r_res.pixel_x;
    assign o_pix.pixel_y      = r_res.pixel_y;
    assign o_pix.byte_address = r_res.byte_address;
    assign o_pix.bit_shift    = r_res.bit_shift;
    assign o_pix.pixel_value  = r_res.pixel_value;
    assign o_pix.last_pixel   = r_res.last_pixel;

    a_beat_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_pix.valid)
        else $error("Accepted command beat produced no result beat.");

    a_load_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_cmd.command == CMD_LOAD |=> !o_pix.write_valid)
        else $error("Load command produced a pixel write.");

    a_last_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.last_pixel |-> o_pix.write_valid)
        else $error("Last pixel flag set on a result without a write.");

endmodule

>>> tb/tb_bresenham_line_pixel_writer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bresenham_line_pixel_writer_top: directed command table, then
// random line sequences under several row widths, random command gaps and result stalls.
// Depends on blw_pkg, the three channel interfaces and the top level of the block.
module tb_bresenham_line_pixel_writer_top;
    import blw_pkg::*;

    localparam int  HOLD_OFF_CYCLES = 64;
    localparam int  DRAIN_CYCLES    = 2000;
    localparam real RUN_LIMIT_NS    = 5_000_000.0;

    typedef struct {
        t_in  cmd;
        bit   has_want;
        t_res want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    blw_in_if  cmd_ch ();
    blw_cfg_if cfg_ch ();
    blw_out_if pix_ch ();

    bresenham_line_pixel_writer_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_pix   (pix_ch)
    );

    // Shadow of the rasterizer state and of the row width register.
    logic [ROW_BITS-1:0] row_width = ROW_BYTES_RESET;
    logic                ln_active = 1'b0;
    logic                ln_steep = 1'b0;
    t_coord              ln_major = '0;
    t_coord              ln_major_end = '0;
    t_coord              ln_minor = '0;
    int                  ln_err = 0;
    t_coord              ln_major_delta = '0;
    t_coord              ln_minor_delta = '0;
    logic                ln_step_down = 1'b0;
    logic [LEVEL_BITS-1:0] ln_level = '0;

    t_res pixel_writes_due[$];
    bit   want_fixed = 1'b0;
    t_res want_fixed_val = '0;
    bit   burst_mode = 1'b0;

    int fail_count = 0;
    int cmd_beats = 0;
    int load_beats = 0;
    int writes_checked = 0;
    int width_writes = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_coord coord_span(input t_coord a, input t_coord b);
        return (a > b) ? t_coord'(a - b) : t_coord'(b - a);
    endfunction

    function automatic t_res rasterize_step(input t_in c);
        t_res        r;
        t_coord      ax, ay, bx, by, tmp, px, py;
        logic        steep;
        logic        last;
        logic [31:0] addr;
        r = '0;
        if (c.command == CMD_LOAD) begin
            ax = c.start_x;
            ay = c.start_y;
            bx = c.end_x;
            by = c.end_y;
            steep = coord_span(ay, by) > coord_span(ax, bx);
            if (steep) begin
                tmp = ax; ax = ay; ay = tmp;
                tmp = bx; bx = by; by = tmp;
            end
            if (ax > bx) begin
                tmp = ax; ax = bx; bx = tmp;
                tmp = ay; ay = by; by = tmp;
            end
            ln_steep       = steep;
            ln_major       = ax;
            ln_major_end   = bx;
            ln_minor       = ay;
            ln_major_delta = t_coord'(bx - ax);
            ln_minor_delta = coord_span(ay, by);
            ln_err         = int'(ln_major_delta >> 1);
            ln_step_down   = !(ay < by);
            ln_level       = c.gray_level;
            ln_active      = 1'b1;
            return r;
        end
        if (!ln_active)
            return r;
        px   = ln_steep ? ln_minor : ln_major;
        py   = ln_steep ? ln_major : ln_minor;
        last = (ln_major == ln_major_end);
        addr = 32'(px >> 2) + 32'(py) * 32'(row_width);
        r.write_valid  = 1'b1;
        r.pixel_x      = px;
        r.pixel_y      = py;
        r.byte_address = addr[ADDR_BITS-1:0];
        r.bit_shift    = SHIFT_BITS'((3 - int'(px[1:0])) * 2);
        r.pixel_value  = ln_level;
        r.last_pixel   = last;
        ln_err = ln_err - int'(ln_minor_delta);
        if (ln_err < 0) begin
            ln_minor = ln_step_down ? t_coord'(ln_minor - 1'b1) : t_coord'(ln_minor + 1'b1);
            ln_err   = ln_err + int'(ln_major_delta);
        end
        if (last)
            ln_active = 1'b0;
        else
            ln_major = t_coord'(ln_major + 1'b1);
        return r;
    endfunction

    function automatic string res_text(input t_res r);
        return $sformatf("wv=%0b x=%0d y=%0d addr=%0d shift=%0d value=%0d last=%0b",
                         r.write_valid, r.pixel_x, r.pixel_y, r.byte_address,
                         r.bit_shift, r.pixel_value, r.last_pixel);
    endfunction

    task automatic flag_failure(input string what, input t_res want, input t_res got);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] ERROR %s: expected {%s} got {%s}", $time, what,
                     res_text(want), res_text(got));
    endtask

    task automatic check_pixel(input t_res want, input t_res got);
        string bad;
        bad = "";
        if (got.write_valid !== want.write_valid)   bad = {bad, " write_valid"};
        if (got.pixel_x !== want.pixel_x)           bad = {bad, " pixel_x"};
        if (got.pixel_y !== want.pixel_y)           bad = {bad, " pixel_y"};
        if (got.byte_address !== want.byte_address) bad = {bad, " byte_address"};
        if (got.bit_shift !== want.bit_shift)       bad = {bad, " bit_shift"};
        if (got.pixel_value !== want.pixel_value)   bad = {bad, " pixel_value"};
        if (got.last_pixel !== want.last_pixel)     bad = {bad, " last_pixel"};
        if (bad != "")
            flag_failure({"wrong", bad}, want, got);
    endtask

    always @(posedge clk) begin : scoreboard
        t_res got;
        t_in  cmd;
        t_res pred;
        if (rst_n) begin
            if (pix_ch.valid && pix_ch.ready) begin
                got = '{write_valid: pix_ch.write_valid, pixel_x: pix_ch.pixel_x,
                        pixel_y: pix_ch.pixel_y, byte_address: pix_ch.byte_address,
                        bit_shift: pix_ch.bit_shift, pixel_value: pix_ch.pixel_value,
                        last_pixel: pix_ch.last_pixel};
                if (pixel_writes_due.size() == 0) begin
                    flag_failure("result beat with nothing expected", '0, got);
                end else begin
                    check_pixel(pixel_writes_due.pop_front(), got);
                    if (got.write_valid)
                        writes_checked++;
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                row_width = cfg_ch.row_bytes;
                width_writes++;
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                cmd = '{command: cmd_ch.command, start_x: cmd_ch.start_x,
                        start_y: cmd_ch.start_y, end_x: cmd_ch.end_x, end_y: cmd_ch.end_y,
                        gray_level: cmd_ch.gray_level};
                pred = rasterize_step(cmd);
                pixel_writes_due.push_back(want_fixed ? want_fixed_val : pred);
                cmd_beats++;
                if (cmd.command == CMD_LOAD)
                    load_beats++;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // Result side: random stalls, quiet stretches, and one long hold-off once traffic runs.
    initial begin : pixel_sink
        int  stall_left;
        bit  quiet;
        bit  held_off;
        stall_left = 0;
        quiet = 1'b0;
        held_off = 1'b0;
        pix_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!held_off && cmd_beats >= 150) begin
                held_off = 1'b1;
                pix_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end else if (stall_left > 0) begin
                pix_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_ch.ready <= 1'b1;
                if ($urandom_range(0, 79) == 0)
                    quiet = !quiet;
                if (!quiet)
                    stall_left = pick_gap();
            end
        end
    end

    function automatic t_in make_load(input int sx, input int sy, input int ex, input int ey,
                                      input int lvl);
        t_in c;
        c.command    = CMD_LOAD;
        c.start_x    = t_coord'(sx);
        c.start_y    = t_coord'(sy);
        c.end_x      = t_coord'(ex);
        c.end_y      = t_coord'(ey);
        c.gray_level = LEVEL_BITS'(lvl);
        return c;
    endfunction

    function automatic t_in make_advance();
        t_in c;
        c = make_load($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 3));
        c.command = CMD_ADVANCE;
        return c;
    endfunction

    function automatic t_res pixel_write(input int x, input int y, input int addr,
                                         input int shift, input int lvl);
        t_res r;
        r = '0;
        r.write_valid  = 1'b1;
        r.pixel_x      = t_coord'(x);
        r.pixel_y      = t_coord'(y);
        r.byte_address = ADDR_BITS'(addr);
        r.bit_shift    = SHIFT_BITS'(shift);
        r.pixel_value  = LEVEL_BITS'(lvl);
        r.last_pixel   = 1'b1;
        return r;
    endfunction

    task automatic send_cmd(input t_in c, input bit has_want, input t_res want);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= c.command;
        cmd_ch.start_x    <= c.start_x;
        cmd_ch.start_y    <= c.start_y;
        cmd_ch.end_x      <= c.end_x;
        cmd_ch.end_y      <= c.end_y;
        cmd_ch.gray_level <= c.gray_level;
        want_fixed     = has_want;
        want_fixed_val = want;
        do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    endtask

    task automatic drain_results();
        int waited;
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        waited = 0;
        while (pixel_writes_due.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_row_width(input logic [ROW_BITS-1:0] w);
        drain_results();
        @(negedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.row_bytes <= w;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_lines(input int n_items);
        int sent, x0, y0, x1, y1, dx, dy, n_adv, r;
        sent = 0;
        while (sent < n_items) begin
            x0 = $urandom_range(0, 1023);
            y0 = $urandom_range(0, 1023);
            if ($urandom_range(0, 4) == 0) begin
                x1 = $urandom_range(0, 1023);
                y1 = $urandom_range(0, 1023);
            end else begin
                x1 = x0 + $urandom_range(0, 24) - 12;
                y1 = y0 + $urandom_range(0, 24) - 12;
                x1 = (x1 < 0) ? 0 : ((x1 > 1023) ? 1023 : x1);
                y1 = (y1 < 0) ? 0 : ((y1 > 1023) ? 1023 : y1);
            end
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            n_adv = ((dx > dy) ? dx : dy) + 1;
            r = $urandom_range(0, 9);
            if (n_adv > 40 || r == 0)
                n_adv = $urandom_range(0, (n_adv > 40) ? 40 : n_adv);
            else if (r == 1)
                n_adv = n_adv + $urandom_range(1, 3);
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 19) == 0) begin
                send_cmd(make_advance(), 1'b0, '0);
                sent++;
            end
            send_cmd(make_load(x0, y0, x1, y1, $urandom_range(0, 3)), 1'b0, '0);
            sent++;
            repeat (n_adv) begin
                send_cmd(make_advance(), 1'b0, '0);
                sent++;
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin : stimulus
        t_dir_row            dir_rows[$];
        logic [ROW_BITS-1:0] widths[$];
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_LOAD;
        cmd_ch.start_x    = '0;
        cmd_ch.start_y    = '0;
        cmd_ch.end_x      = '0;
        cmd_ch.end_y      = '0;
        cmd_ch.gray_level = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.row_bytes  = ROW_BYTES_RESET;
        rst_n             = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        dir_rows.push_back('{make_advance(), 1'b1, '0});
        dir_rows.push_back('{make_load(0, 0, 0, 0, 3), 1'b1, '0});
        dir_rows.push_back('{make_advance(), 1'b1, pixel_write(0, 0, 0, 6, 3)});
        dir_rows.push_back('{make_advance(), 1'b1, '0});
        dir_rows.push_back('{make_load(1023, 1023, 1023, 1023, 2), 1'b1, '0});
        dir_rows.push_back('{make_advance(), 1'b1, pixel_write(1023, 1023, 75957, 0, 2)});
        dir_rows.push_back('{make_load(0, 5, 6, 5, 1), 1'b1, '0});
        repeat (3) dir_rows.push_back('{make_advance(), 1'b0, '0});
        dir_rows.push_back('{make_load(3, 1000, 0, 990, 0), 1'b1, '0});
        repeat (3) dir_rows.push_back('{make_advance(), 1'b0, '0});
        dir_rows.push_back('{make_load(1023, 0, 0, 1023, 3), 1'b1, '0});
        repeat (2) dir_rows.push_back('{make_advance(), 1'b0, '0});
        dir_rows.push_back('{make_load(10, 20, 13, 2, 2), 1'b1, '0});
        repeat (3) dir_rows.push_back('{make_advance(), 1'b0, '0});
        dir_rows.push_back('{make_load(682, 341, 341, 682, 1), 1'b1, '0});
        repeat (2) dir_rows.push_back('{make_advance(), 1'b0, '0});
        foreach (dir_rows[k])
            send_cmd(dir_rows[k].cmd, dir_rows[k].has_want, dir_rows[k].want);

        widths = '{9'd1, 9'd256, 9'd511, 9'd0, ROW_BITS'($urandom_range(2, 255)),
                   ROW_BYTES_RESET};
        foreach (widths[k]) begin
            set_row_width(widths[k]);
            run_lines(80);
        end
        drain_results();

        while (pixel_writes_due.size() != 0) begin
            flag_failure("expected beat never arrived", pixel_writes_due.pop_front(), '0);
        end
        $display("Ran %0d command beats (%0d loads) over %0d row width writes;",
                 cmd_beats, load_beats, width_writes);
        $display("checked %0d pixel writes plus every non-write result, %0d failures.",
                 writes_checked, fail_count);
        if (fail_count == 0) begin
            $display("bresenham_line_pixel_writer_top: match");
        end else begin
            $display("bresenham_line_pixel_writer_top: mismatch");
        end
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d results still due.", pixel_writes_due.size());
        $display("bresenham_line_pixel_writer_top: mismatch");
        $finish;
    end

endmodule
